[sv/lca_pkg.sv]
// ----------------------------------------------------------------------------
// lca_pkg
// Shared widths, command codes and interface structs for the lowest common
// ancestor unit (binary lifting).
// ----------------------------------------------------------------------------
package lca_pkg;

    // tree geometry
    localparam int NODE_BITS   = 10;
    localparam int NODE_COUNT  = 1 << NODE_BITS;
    localparam int LEVEL_BITS  = 4;
    localparam int LIFT_LEVELS = 11;
    localparam int DEPTH_BITS  = 11;
    localparam int CMD_BITS    = 2;

    // ancestor table is addressed as {node, level}
    localparam int ANC_ADDR_BITS = NODE_BITS + LEVEL_BITS;
    localparam int ANC_ENTRIES   = 1 << ANC_ADDR_BITS;

    localparam logic [LEVEL_BITS-1:0] TOP_LEVEL   = LEVEL_BITS'(LIFT_LEVELS - 1);
    localparam logic [LEVEL_BITS:0]   LEVEL_LIMIT = (LEVEL_BITS + 1)'(LIFT_LEVELS);

    // stream widths
    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 16;
    localparam int IN_PAD_BITS   = IN_DATA_BITS - (3 * NODE_BITS + LEVEL_BITS + DEPTH_BITS);
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - NODE_BITS;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_WR_ANC   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WR_DEPTH = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_QUERY    = 2'd2;

    // input word layout, last field (node) in the lowest bits
    typedef struct packed {
        logic [IN_PAD_BITS-1:0] pad;
        logic [NODE_BITS-1:0]   other_node;
        logic [DEPTH_BITS-1:0]  node_depth;
        logic [NODE_BITS-1:0]   ancestor;
        logic [LEVEL_BITS-1:0]  level;
        logic [NODE_BITS-1:0]   node;
    } in_data_t;

    // depth store write port
    typedef struct packed {
        logic                  en;
        logic [NODE_BITS-1:0]  node;
        logic [DEPTH_BITS-1:0] depth;
    } dep_wr_t;

    // depth store read addresses
    typedef struct packed {
        logic [NODE_BITS-1:0] node_a;
        logic [NODE_BITS-1:0] node_b;
    } dep_rd_t;

    // ancestor table write port
    typedef struct packed {
        logic                  en;
        logic [NODE_BITS-1:0]  node;
        logic [LEVEL_BITS-1:0] level;
        logic [NODE_BITS-1:0]  ancestor;
    } anc_wr_t;

    // ancestor table read addresses
    typedef struct packed {
        logic [NODE_BITS-1:0]  node_a;
        logic [LEVEL_BITS-1:0] level_a;
        logic [NODE_BITS-1:0]  node_b;
        logic [LEVEL_BITS-1:0] level_b;
    } anc_rd_t;

    // query start from the input side
    typedef struct packed {
        logic                 start;
        logic [NODE_BITS-1:0] node;
        logic [NODE_BITS-1:0] other_node;
    } qry_start_t;

    // sequencer status toward the output side
    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [NODE_BITS-1:0] result;
    } qry_status_t;

endpackage

[sv/lca_binary_lifting_unit.sv]
// ----------------------------------------------------------------------------
// lca_binary_lifting_unit
// Lowest common ancestor by binary lifting over a stream interface.
// ----------------------------------------------------------------------------
// Each input word carries a command in tuser: write one ancestor entry, write
// one node depth, or ask for the lowest common ancestor of two nodes. Writes
// give no output word. A query gives one output word; the time from its
// acceptance to the answer entering the output register is set by the
// depth-matching pass, where each of the 11 levels chains an ancestor memory
// read into a depth memory read, and, unless that pass already meets the
// other node, by a common pass over every level that follows it. The block
// takes no new word while a query is being worked on, but it does while an
// answer waits in the output register. After reset the depth store clears
// all 1024 entries, and during that pass no input word is accepted. Writes
// to node 0 and ancestor writes at levels 11 and above are ignored; command
// 3 is accepted and ignored.
// ----------------------------------------------------------------------------
module lca_binary_lifting_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // node, level, ancestor, node_depth, other_node, zero pad
    input  logic [lca_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
    // command
    input  logic [lca_pkg::CMD_BITS-1:0]          s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // common_ancestor, zero pad
    output logic [lca_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);

    lca_pkg::in_data_t    in_word;
    lca_pkg::dep_wr_t     dep_wr;
    lca_pkg::dep_rd_t     dep_rd;
    lca_pkg::anc_wr_t     anc_wr;
    lca_pkg::anc_rd_t     anc_rd;
    lca_pkg::qry_start_t  qry_start;
    lca_pkg::qry_status_t qry_status;

    logic                             in_accept;
    logic                             node_live;
    logic                             clear_done;
    logic                             out_free;
    logic [lca_pkg::DEPTH_BITS-1:0]   depth_a;
    logic [lca_pkg::DEPTH_BITS-1:0]   depth_b;
    logic [lca_pkg::NODE_BITS-1:0]    anc_a;
    logic [lca_pkg::NODE_BITS-1:0]    anc_b;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [lca_pkg::NODE_BITS-1:0]    out_data_reg;
    logic [lca_pkg::NODE_BITS-1:0]    out_data_next;

    // input side handshake and command decode
    assign in_word       = lca_pkg::in_data_t'(s_axis_tdata);
    assign s_axis_tready = clear_done && !qry_status.busy;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign node_live     = (in_word.node != '0);

    assign dep_wr.en    = in_accept && (s_axis_tuser == lca_pkg::CMD_WR_DEPTH) && node_live;
    assign dep_wr.node  = in_word.node;
    assign dep_wr.depth = in_word.node_depth;

    assign anc_wr.en       = in_accept && (s_axis_tuser == lca_pkg::CMD_WR_ANC) && node_live
                             && ({1'b0, in_word.level} < lca_pkg::LEVEL_LIMIT);
    assign anc_wr.node     = in_word.node;
    assign anc_wr.level    = in_word.level;
    assign anc_wr.ancestor = in_word.ancestor;

    assign qry_start.start      = in_accept && (s_axis_tuser == lca_pkg::CMD_QUERY);
    assign qry_start.node       = in_word.node;
    assign qry_start.other_node = in_word.other_node;

    // storage
    lca_depth_store u_depth_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (dep_wr),
        .rd         (dep_rd),
        .depth_a    (depth_a),
        .depth_b    (depth_b),
        .clear_done (clear_done)
    );

    lca_anc_table u_anc_table (
        .clk   (clk),
        .wr    (anc_wr),
        .rd    (anc_rd),
        .anc_a (anc_a),
        .anc_b (anc_b)
    );

    // query sequencer
    lca_query_seq u_query_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (qry_start),
        .out_free (out_free),
        .status   (qry_status),
        .dep_rd   (dep_rd),
        .depth_a  (depth_a),
        .depth_b  (depth_b),
        .anc_rd   (anc_rd),
        .anc_a    (anc_a),
        .anc_b    (anc_b)
    );

    // output register
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (qry_status.done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = qry_status.result;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{lca_pkg::OUT_PAD_BITS{1'b0}}, out_data_reg};

    // an answer never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        qry_status.done |-> out_free)
        else $error("answer handed over while output word still pending");

    // a query start always occupies the sequencer on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        qry_start.start |=> qry_status.busy)
        else $error("query started but sequencer not busy");

    // no memory write or query start while the depth store is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !(dep_wr.en || anc_wr.en || qry_start.start))
        else $error("input word taken during clearing pass");

endmodule

[sv/lca_depth_store.sv]
// ----------------------------------------------------------------------------
// lca_depth_store
// Node depth memory with one write port and two registered read ports.
// After reset a clearing pass zeroes every entry, one per cycle.
// ----------------------------------------------------------------------------
module lca_depth_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lca_pkg::dep_wr_t                   wr,
    input  lca_pkg::dep_rd_t                   rd,
    output logic [lca_pkg::DEPTH_BITS-1:0]     depth_a,
    output logic [lca_pkg::DEPTH_BITS-1:0]     depth_b,
    output logic                               clear_done
);

    logic [lca_pkg::DEPTH_BITS-1:0] mem [lca_pkg::NODE_COUNT];

    logic [lca_pkg::NODE_BITS:0]    clr_cnt_reg;
    logic [lca_pkg::NODE_BITS:0]    clr_cnt_next;
    logic                           mem_we;
    logic [lca_pkg::NODE_BITS-1:0]  mem_waddr;
    logic [lca_pkg::DEPTH_BITS-1:0] mem_wdata;
    logic [lca_pkg::DEPTH_BITS-1:0] rd_a_reg;
    logic [lca_pkg::DEPTH_BITS-1:0] rd_b_reg;

    // clearing pass counter, top bit set once every entry is zeroed
    assign clear_done   = clr_cnt_reg[lca_pkg::NODE_BITS];
    assign clr_cnt_next = clear_done ? clr_cnt_reg : clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // write port shared by the clearing pass and depth writes
    always_comb
    begin
        if (!clear_done)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[lca_pkg::NODE_BITS-1:0];
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr.en;
            mem_waddr = wr.node;
            mem_wdata = wr.depth;
        end
    end

    // memory array with registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[rd.node_a];
        rd_b_reg <= mem[rd.node_b];
    end

    assign depth_a = rd_a_reg;
    assign depth_b = rd_b_reg;

endmodule

[sv/lca_anc_table.sv]
// ----------------------------------------------------------------------------
// lca_anc_table
// Binary-lifting ancestor memory addressed by {node, level}, one write port
// and two registered read ports. Reads of the sentinel node return zero.
// ----------------------------------------------------------------------------
module lca_anc_table (
    input  logic                              clk,
    input  lca_pkg::anc_wr_t                  wr,
    input  lca_pkg::anc_rd_t                  rd,
    output logic [lca_pkg::NODE_BITS-1:0]     anc_a,
    output logic [lca_pkg::NODE_BITS-1:0]     anc_b
);

    logic [lca_pkg::NODE_BITS-1:0] mem [lca_pkg::ANC_ENTRIES];

    logic [lca_pkg::NODE_BITS-1:0] rd_a_reg;
    logic [lca_pkg::NODE_BITS-1:0] rd_b_reg;
    logic                          zero_a_reg;
    logic                          zero_b_reg;

    // memory array with registered reads
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[{wr.node, wr.level}] <= wr.ancestor;
        end
        rd_a_reg   <= mem[{rd.node_a, rd.level_a}];
        rd_b_reg   <= mem[{rd.node_b, rd.level_b}];
        zero_a_reg <= (rd.node_a == '0);
        zero_b_reg <= (rd.node_b == '0);
    end

    // sentinel rows are never written and always read as zero
    assign anc_a = zero_a_reg ? '0 : rd_a_reg;
    assign anc_b = zero_b_reg ? '0 : rd_b_reg;

endmodule

[sv/lca_query_seq.sv]
// ----------------------------------------------------------------------------
// lca_query_seq
// Query sequencer: orders the two nodes by depth, lifts the deeper one to the
// other's depth, then lifts both while their ancestors differ. One depth
// comparator is shared by the ordering and the lifting steps.
// ----------------------------------------------------------------------------
module lca_query_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lca_pkg::qry_start_t               start,
    input  logic                              out_free,
    output lca_pkg::qry_status_t              status,
    output lca_pkg::dep_rd_t                  dep_rd,
    input  logic [lca_pkg::DEPTH_BITS-1:0]    depth_a,
    input  logic [lca_pkg::DEPTH_BITS-1:0]    depth_b,
    output lca_pkg::anc_rd_t                  anc_rd,
    input  logic [lca_pkg::NODE_BITS-1:0]     anc_a,
    input  logic [lca_pkg::NODE_BITS-1:0]     anc_b
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_SORT   = 3'd2;
    localparam logic [2:0] ST_L1_DEP = 3'd3;
    localparam logic [2:0] ST_L1_CMP = 3'd4;
    localparam logic [2:0] ST_L2_CMP = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [lca_pkg::NODE_BITS-1:0]   a_reg;
    logic [lca_pkg::NODE_BITS-1:0]   a_next;
    logic [lca_pkg::NODE_BITS-1:0]   b_reg;
    logic [lca_pkg::NODE_BITS-1:0]   b_next;
    logic [lca_pkg::NODE_BITS-1:0]   p_reg;
    logic [lca_pkg::NODE_BITS-1:0]   p_next;
    logic [lca_pkg::DEPTH_BITS-1:0]  depth_b_reg;
    logic [lca_pkg::DEPTH_BITS-1:0]  depth_b_next;
    logic [lca_pkg::LEVEL_BITS-1:0]  k_reg;
    logic [lca_pkg::LEVEL_BITS-1:0]  k_next;

    logic [lca_pkg::DEPTH_BITS-1:0]  cmp_rhs;
    logic                            cmp_ge;
    logic                            swap;
    logic                            differ;
    logic [lca_pkg::NODE_BITS-1:0]   a_new;
    logic [lca_pkg::NODE_BITS-1:0]   b_new;
    logic [lca_pkg::LEVEL_BITS-1:0]  k_dec;

    // shared depth comparator: port a depth against the other node's depth
    assign cmp_rhs = (state_reg == ST_SORT) ? depth_b : depth_b_reg;
    assign cmp_ge  = (depth_a >= cmp_rhs);
    assign swap    = !cmp_ge;
    assign differ  = (anc_a != anc_b);
    assign k_dec   = k_reg - 1'b1;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        p_next         = p_reg;
        depth_b_next   = depth_b_reg;
        k_next         = k_reg;
        a_new          = a_reg;
        b_new          = b_reg;
        dep_rd.node_a  = a_reg;
        dep_rd.node_b  = b_reg;
        anc_rd.node_a  = a_reg;
        anc_rd.level_a = k_reg;
        anc_rd.node_b  = b_reg;
        anc_rd.level_b = k_reg;
        status.busy    = (state_reg != ST_IDLE);
        status.done    = 1'b0;
        status.result  = a_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start.start)
                begin
                    a_next     = start.node;
                    b_next     = start.other_node;
                    state_next = ST_START;
                end
            end

            // depth reads of both nodes are in flight
            ST_START:
            begin
                state_next = ST_SORT;
            end

            // deeper node goes first, then read its top-level ancestor
            ST_SORT:
            begin
                a_new          = swap ? b_reg : a_reg;
                b_new          = swap ? a_reg : b_reg;
                a_next         = a_new;
                b_next         = b_new;
                depth_b_next   = swap ? depth_a : depth_b;
                k_next         = lca_pkg::TOP_LEVEL;
                anc_rd.node_a  = a_new;
                anc_rd.level_a = lca_pkg::TOP_LEVEL;
                state_next     = ST_L1_DEP;
            end

            // ancestor arrived, look up its depth
            ST_L1_DEP:
            begin
                p_next        = anc_a;
                dep_rd.node_a = anc_a;
                state_next    = ST_L1_CMP;
            end

            // take the jump if it does not overshoot the other node's depth
            ST_L1_CMP:
            begin
                a_new  = cmp_ge ? p_reg : a_reg;
                a_next = a_new;
                if (k_reg != '0)
                begin
                    k_next         = k_dec;
                    anc_rd.node_a  = a_new;
                    anc_rd.level_a = k_dec;
                    state_next     = ST_L1_DEP;
                end
                else if (a_new == b_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next         = lca_pkg::TOP_LEVEL;
                    anc_rd.node_a  = a_new;
                    anc_rd.level_a = lca_pkg::TOP_LEVEL;
                    anc_rd.node_b  = b_reg;
                    anc_rd.level_b = lca_pkg::TOP_LEVEL;
                    state_next     = ST_L2_CMP;
                end
            end

            // lift both nodes where their ancestors differ
            ST_L2_CMP:
            begin
                a_new  = differ ? anc_a : a_reg;
                b_new  = differ ? anc_b : b_reg;
                a_next = a_new;
                b_next = b_new;
                anc_rd.node_a = a_new;
                anc_rd.node_b = b_new;
                if (k_reg != '0)
                begin
                    k_next         = k_dec;
                    anc_rd.level_a = k_dec;
                    anc_rd.level_b = k_dec;
                end
                else
                begin
                    anc_rd.level_a = '0;
                    anc_rd.level_b = '0;
                    state_next     = ST_FIN;
                end
            end

            // parent of the lifted node is the answer
            ST_FIN:
            begin
                a_next     = anc_a;
                state_next = ST_DONE;
            end

            // hand the answer over once the output register is free
            ST_DONE:
            begin
                if (out_free)
                begin
                    status.done = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        p_reg       <= p_next;
        depth_b_reg <= depth_b_next;
        k_reg       <= k_next;
    end

endmodule
